// ===== rtl/ata_task_file_builder_assert.svh =====
// Assertion macros shared by the ATA task-file builder RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ATA_TASK_FILE_BUILDER_ASSERT_SVH
`define ATA_TASK_FILE_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define ATF_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("ata task file: same-cycle check failed");
`define ATF_ASSERT_NXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("ata task file: next-cycle check failed");
`else
`define ATF_ASSERT_IMP(lbl, cond, prop)
`define ATF_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

// ===== rtl/atf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ATA task-file builder.
// No dependencies; used by atf_emit and ata_task_file_builder.
package atf_pkg;

   localparam logic [31:0] LBA48_LIMIT = 32'h1000_0000;

   // Exact division of a 28-bit address by 63: q = (a * RECIP_63) >> RECIP_SHIFT.
   localparam int          RECIP_SHIFT = 34;
   localparam logic [28:0] RECIP_63    = 29'd272696337;
   localparam logic [5:0]  SECTORS_PER_TRACK = 6'd63;

   localparam logic [7:0] CTRL_NIEN     = 8'h02;
   localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
   localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_READ_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   localparam logic [1:0] MODE_CHS   = 2'd0;
   localparam logic [1:0] MODE_LBA28 = 2'd1;
   localparam logic [1:0] MODE_LBA48 = 2'd2;

   localparam logic [3:0] REG_CONTROL    = 4'd0;
   localparam logic [3:0] REG_DEVICE     = 4'd1;
   localparam logic [3:0] REG_COUNT_HIGH = 4'd2;
   localparam logic [3:0] REG_LBA3       = 4'd3;
   localparam logic [3:0] REG_LBA4       = 4'd4;
   localparam logic [3:0] REG_LBA5       = 4'd5;
   localparam logic [3:0] REG_COUNT_LOW  = 4'd6;
   localparam logic [3:0] REG_LBA0       = 4'd7;
   localparam logic [3:0] REG_LBA1       = 4'd8;
   localparam logic [3:0] REG_LBA2       = 4'd9;
   localparam logic [3:0] REG_COMMAND    = 4'd10;

   // Everything the sequencer needs to replay one request.
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] devsel;
      logic [7:0] count;
      logic [7:0] lba0;
      logic [7:0] lba1;
      logic [7:0] lba2;
      logic [7:0] lba3;
      logic [7:0] command;
   } item_type;

endpackage

// ===== rtl/atf_emit.sv =====
`timescale 1ns / 1ps
// Sequencer that turns one prepared request into its task-file register writes.
// Depends on atf_pkg and ata_task_file_builder_assert.svh.
`include "ata_task_file_builder_assert.svh"
module atf_emit import atf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  item_type   in_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_register_index,
   output logic [7:0] rsp_write_data,
   output logic [1:0] rsp_addressing_mode,
   output logic       rsp_last_write
);

   logic       busy_ff, busy_in;
   logic [3:0] idx_ff, idx_in;
   item_type   item_ff, item_in;
   logic       done;
   logic       load;

   // The next request loads in the same cycle the command write is taken.
   assign done     = busy_ff && !rsp_stall && (idx_ff == REG_COMMAND);
   assign in_stall = busy_ff && !done;
   assign load     = in_valid && !in_stall;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      item_in = item_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = REG_CONTROL;
         item_in = in_item;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && !rsp_stall) begin
         // Only LBA48 writes the high-order count and address registers.
         if (idx_ff == REG_DEVICE && item_ff.mode != MODE_LBA48) begin
            idx_in = REG_COUNT_LOW;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff  <= idx_in;
      item_ff <= item_in;
   end

   always_comb begin
      unique case (idx_ff) inside
         REG_CONTROL:                          rsp_write_data = CTRL_NIEN;
         REG_DEVICE:                           rsp_write_data = item_ff.devsel;
         REG_COUNT_HIGH, REG_LBA4, REG_LBA5:   rsp_write_data = 8'h00;
         REG_LBA3:                             rsp_write_data = item_ff.lba3;
         REG_COUNT_LOW:                        rsp_write_data = item_ff.count;
         REG_LBA0:                             rsp_write_data = item_ff.lba0;
         REG_LBA1:                             rsp_write_data = item_ff.lba1;
         REG_LBA2:                             rsp_write_data = item_ff.lba2;
         REG_COMMAND:                          rsp_write_data = item_ff.command;
         default:                              rsp_write_data = 8'h00;
      endcase
   end

   assign rsp_valid           = busy_ff;
   assign rsp_register_index  = idx_ff;
   assign rsp_addressing_mode = item_ff.mode;
   assign rsp_last_write      = (idx_ff == REG_COMMAND);

   `ATF_ASSERT_IMP(a_short_skips_high, rsp_valid && rsp_addressing_mode != MODE_LBA48, rsp_register_index < REG_COUNT_HIGH || rsp_register_index > REG_LBA5)
   `ATF_ASSERT_NXT(a_sequence_continues, rsp_valid && !rsp_stall && !rsp_last_write, rsp_valid && rsp_register_index != REG_CONTROL)
   `ATF_ASSERT_NXT(a_lba48_goes_high, rsp_valid && !rsp_stall && rsp_register_index == REG_DEVICE && rsp_addressing_mode == MODE_LBA48, rsp_register_index == REG_COUNT_HIGH)
   `ATF_ASSERT_IMP(a_index_in_range, rsp_valid, rsp_register_index <= REG_COMMAND)

endmodule

// ===== rtl/ata_task_file_builder.sv =====
`timescale 1ns / 1ps
// A request's control write is offered once it has passed the three address stages and
// been loaded into the sequencer. A CHS or LBA28 request makes 7 register writes and an
// LBA48 request 11, at the sequencer's one register write per cycle while rsp_stall is
// low; the three-stage address pipeline accepts a new request every cycle until it fills.
// Reset (synchronous, active high) clears only the valid bits.
// Depends on atf_pkg and atf_emit.
module ata_task_file_builder import atf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_block_address,
   input  logic [7:0]  req_sector_count,
   input  logic        req_drive_select,
   input  logic        req_lba_supported,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_register_index,
   output logic [7:0]  rsp_write_data,
   output logic [1:0]  rsp_addressing_mode,
   output logic        rsp_last_write
);

   // Stage 1: request capture and reciprocal multiply.
   logic        s1_valid_ff;
   logic        s1_action_ff, s1_drive_ff, s1_lba_ok_ff;
   logic [31:0] s1_addr_ff;
   logic [7:0]  s1_count_ff;
   logic [56:0] s1_prod_ff, s1_prod_in;

   // Stage 2: quotient and remainder by 63.
   logic        s2_valid_ff;
   logic        s2_action_ff, s2_drive_ff, s2_lba_ok_ff;
   logic [31:0] s2_addr_ff;
   logic [7:0]  s2_count_ff;
   logic [22:0] s2_quot_ff, s2_quot_in;
   logic [5:0]  s2_rem_ff, s2_rem_in;
   logic [28:0] s2_back;

   // Stage 3: prepared task-file bytes.
   logic        s3_valid_ff;
   item_type    s3_item_ff, s3_item_in;
   logic [3:0]  s3_head;
   logic [7:0]  s3_sector;

   logic        emit_stall;
   logic        s1_adv, s2_adv, s3_adv;

   assign s3_adv    = !s3_valid_ff || !emit_stall;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   assign s1_prod_in = 57'(req_block_address[27:0] * RECIP_63);

   assign s2_quot_in = s1_prod_ff[RECIP_SHIFT +: 23];
   // The remainder is below 64, so its low six bits are exact.
   assign s2_back    = 29'(s2_quot_in * SECTORS_PER_TRACK);
   assign s2_rem_in  = s1_addr_ff[5:0] - s2_back[5:0];

   always_comb begin
      s3_item_in.count = s2_count_ff;
      s3_item_in.lba3  = s2_addr_ff[31:24];
      s3_sector        = {2'b00, s2_rem_ff} + 8'd1;
      if (s2_addr_ff >= LBA48_LIMIT) begin
         s3_item_in.mode = MODE_LBA48;
         s3_head         = 4'd0;
      end else if (s2_lba_ok_ff) begin
         s3_item_in.mode = MODE_LBA28;
         s3_head         = s2_addr_ff[27:24];
      end else begin
         s3_item_in.mode = MODE_CHS;
         s3_head         = s2_quot_ff[3:0];
      end
      if (s3_item_in.mode == MODE_CHS) begin
         s3_item_in.devsel = DEVSEL_CHS | {3'b000, s2_drive_ff, s3_head};
         s3_item_in.lba0   = s3_sector;
         s3_item_in.lba1   = s2_quot_ff[11:4];
         s3_item_in.lba2   = s2_quot_ff[19:12];
      end else begin
         s3_item_in.devsel = DEVSEL_LBA | {3'b000, s2_drive_ff, s3_head};
         s3_item_in.lba0   = s2_addr_ff[7:0];
         s3_item_in.lba1   = s2_addr_ff[15:8];
         s3_item_in.lba2   = s2_addr_ff[23:16];
      end
      if (s3_item_in.mode == MODE_LBA48) begin
         s3_item_in.command = s2_action_ff ? CMD_WRITE_EXT : CMD_READ_EXT;
      end else begin
         s3_item_in.command = s2_action_ff ? CMD_WRITE : CMD_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
      if (s1_adv) begin
         s1_action_ff <= req_action;
         s1_addr_ff   <= req_block_address;
         s1_count_ff  <= req_sector_count;
         s1_drive_ff  <= req_drive_select;
         s1_lba_ok_ff <= req_lba_supported;
         s1_prod_ff   <= s1_prod_in;
      end
      if (s2_adv) begin
         s2_action_ff <= s1_action_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_count_ff  <= s1_count_ff;
         s2_drive_ff  <= s1_drive_ff;
         s2_lba_ok_ff <= s1_lba_ok_ff;
         s2_quot_ff   <= s2_quot_in;
         s2_rem_ff    <= s2_rem_in;
      end
      if (s3_adv) begin
         s3_item_ff <= s3_item_in;
      end
   end

   atf_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (s3_valid_ff),
      .in_stall            (emit_stall),
      .in_item             (s3_item_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_index  (rsp_register_index),
      .rsp_write_data      (rsp_write_data),
      .rsp_addressing_mode (rsp_addressing_mode),
      .rsp_last_write      (rsp_last_write)
   );

endmodule
